// ----- hdl/oaht_pkg.sv -----
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared constants, types and the home-slot hash for the open-addressed
// hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

    // Table geometry: the slot count is always a power of two
    localparam int SLOT_BITS   = 14;
    localparam int TABLE_SLOTS = 1 << SLOT_BITS;
    localparam int PROBE_BITS  = SLOT_BITS + 1;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 16;

    // Stream widths
    localparam int IN_DATA_BITS  = KEY_BITS + VALUE_BITS;
    localparam int OUT_DATA_BITS = VALUE_BITS;

    // Request queue between the front and back parts
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [KEY_BITS-1:0] HASH_SEED = 32'd5381;

    // Request modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FOUND    = 2'd1;
    localparam logic [1:0] ST_MISSING  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Classified request, as it travels from front to back
    typedef struct packed {
        logic                  mode;
        logic                  key_zero;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [SLOT_BITS-1:0]  home;
    } t_req;

    // djb2 over the four key bytes, low byte first. Only the slot bits are
    // kept: multiply by 33 and xor never carry from high bits into low bits.
    function automatic logic [SLOT_BITS-1:0] home_slot(input logic [KEY_BITS-1:0] key);
        logic [SLOT_BITS-1:0] h;
        h = SLOT_BITS'(HASH_SEED);
        for (int b = 0; b < 4; b++) begin
            h = (h << 5) + h;
            h = h ^ SLOT_BITS'(key[b*8 +: 8]);
        end
        return h;
    endfunction

endpackage

// ----- hdl/oaht_front.sv -----
// ----------------------------------------------------------------------------
// oaht_front
// Takes requests from the input stream, computes the home slot and flags
// the zero key, then pushes the classified request into the queue.
// ----------------------------------------------------------------------------
module oaht_front
    import oaht_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_enable,     // table clear finished
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [IN_DATA_BITS-1:0] i_s_tdata,    // key, value
    input  logic                    i_s_tuser,    // mode
    output logic                    o_q_valid,
    input  logic                    i_q_ready,
    output t_req                    o_q_req
);

    logic r_seen_reset;

    // Remembers that reset has been released at least once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_reset <= 1'b0;
        end else begin
            r_seen_reset <= 1'b1;
        end
    end

    // Handshake passes straight through to the queue
    assign o_s_tready = i_q_ready && i_enable && r_seen_reset;
    assign o_q_valid  = i_s_tvalid && i_enable && r_seen_reset;

    // Classify the request
    always_comb begin
        o_q_req.mode     = i_s_tuser;
        o_q_req.key      = i_s_tdata[KEY_BITS-1:0];
        o_q_req.value    = i_s_tdata[KEY_BITS +: VALUE_BITS];
        o_q_req.key_zero = (i_s_tdata[KEY_BITS-1:0] == '0);
        o_q_req.home     = home_slot(i_s_tdata[KEY_BITS-1:0]);
    end

endmodule

// ----- hdl/oaht_queue.sv -----
// ----------------------------------------------------------------------------
// oaht_queue
// Short request queue that decouples the front part from the probe engine.
// ----------------------------------------------------------------------------
module oaht_queue
    import oaht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_req i_push_req,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_req o_pop_req
);

    t_req                      r_entry [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr;
    logic [QUEUE_CNT_BITS-1:0] r_count;
    logic                      push;
    logic                      pop;

    assign o_push_ready = (r_count != QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_req    = r_entry[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= i_push_req;
        end
    end

endmodule

// ----- hdl/oaht_back.sv -----
// ----------------------------------------------------------------------------
// oaht_back
// Probe engine: clears the key store after reset, then walks each request's
// triangular probe chain through the key and value memories and registers
// one result per request.
// ----------------------------------------------------------------------------
module oaht_back
    import oaht_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    output logic                  o_cleared,
    input  logic                  i_q_valid,
    output logic                  o_q_ready,
    input  t_req                  i_q_req,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic [1:0]            o_res_status,
    output logic [VALUE_BITS-1:0] o_res_value
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_CHECK = 5'b01000,
        S_HOLD  = 5'b10000
    } t_back_state;

    // Memories
    logic [KEY_BITS-1:0]   r_key_mem [TABLE_SLOTS];
    logic [VALUE_BITS-1:0] r_val_mem [TABLE_SLOTS];
    logic [KEY_BITS-1:0]   r_rd_key;
    logic [VALUE_BITS-1:0] r_rd_val;

    // Control and current request
    t_back_state           r_state, n_state;
    logic [SLOT_BITS-1:0]  r_clr_addr, n_clr_addr;
    logic [SLOT_BITS-1:0]  r_slot, n_slot;
    logic [PROBE_BITS-1:0] r_probe, n_probe;
    logic                  r_mode;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    // Pending and output results
    logic [1:0]            r_res_status;
    logic [VALUE_BITS-1:0] r_res_value;
    logic                  r_out_valid;
    logic [1:0]            r_out_status;
    logic [VALUE_BITS-1:0] r_out_value;

    logic                  key_we;
    logic [SLOT_BITS-1:0]  key_waddr;
    logic [KEY_BITS-1:0]   key_wdata;
    logic                  val_we;
    logic                  pop;
    logic                  out_free;
    logic                  out_load;
    logic [1:0]            out_status;
    logic [VALUE_BITS-1:0] out_value;
    logic                  res_save;
    logic [1:0]            res_status;
    logic [VALUE_BITS-1:0] res_value;
    logic                  slot_empty;
    logic                  slot_hit;

    assign o_cleared    = (r_state != S_CLEAR);
    assign o_q_ready    = pop;
    assign o_res_valid  = r_out_valid;
    assign o_res_status = r_out_status;
    assign o_res_value  = r_out_value;

    assign out_free   = !r_out_valid || i_res_ready;
    assign slot_empty = (r_rd_key == '0);
    assign slot_hit   = (r_rd_key == r_key);

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_slot     = r_slot;
        n_probe    = r_probe;
        key_we     = 1'b0;
        key_waddr  = r_slot;
        key_wdata  = r_key;
        val_we     = 1'b0;
        pop        = 1'b0;
        out_load   = 1'b0;
        out_status = r_res_status;
        out_value  = r_res_value;
        res_save   = 1'b0;
        res_status = ST_FULL;
        res_value  = '0;
        case (r_state)
            S_CLEAR: begin
                key_we     = 1'b1;
                key_waddr  = r_clr_addr;
                key_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == SLOT_BITS'(TABLE_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    pop     = 1'b1;
                    n_slot  = i_q_req.home;
                    n_probe = PROBE_BITS'(1);
                    if (i_q_req.key_zero) begin
                        // zero cannot be stored or found
                        res_save   = 1'b1;
                        res_status = ST_MISSING;
                        n_state    = S_HOLD;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_mode == MODE_INSERT && slot_empty) begin
                    key_we     = 1'b1;
                    val_we     = 1'b1;
                    res_status = ST_INSERTED;
                end else if (r_mode == MODE_LOOKUP && slot_empty) begin
                    res_status = ST_MISSING;
                end else if (r_mode == MODE_LOOKUP && slot_hit) begin
                    res_status = ST_FOUND;
                    res_value  = r_rd_val;
                end else begin
                    res_status = ST_FULL;
                end
                if (res_status == ST_FULL && r_probe != PROBE_BITS'(TABLE_SLOTS)) begin
                    // keep walking: slot advances by the probe number
                    n_slot  = r_slot + r_probe[SLOT_BITS-1:0];
                    n_probe = r_probe + 1'b1;
                    n_state = S_READ;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    out_status = res_status;
                    out_value  = res_value;
                    n_state    = S_IDLE;
                end else begin
                    res_save = 1'b1;
                    n_state  = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_slot  <= n_slot;
        r_probe <= n_probe;
        if (pop) begin
            r_mode  <= i_q_req.mode;
            r_key   <= i_q_req.key;
            r_value <= i_q_req.value;
        end
        if (res_save) begin
            r_res_status <= res_status;
            r_res_value  <= res_value;
        end
        if (out_load) begin
            r_out_status <= out_status;
            r_out_value  <= out_value;
        end
    end

    // Key store: one write port, registered read at the current slot
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[key_waddr] <= key_wdata;
        end
        r_rd_key <= r_key_mem[r_slot];
    end

    // Value store: written on insert only
    always_ff @(posedge i_clk) begin
        if (val_we) begin
            r_val_mem[r_slot] <= r_value;
        end
        r_rd_val <= r_val_mem[r_slot];
    end

endmodule

// ----- hdl/open_address_hash_table.sv -----
// ----------------------------------------------------------------------------
// open_address_hash_table
// Open-addressed hash table of nonzero 32-bit keys with 16-bit value handles.
// ----------------------------------------------------------------------------
// Requests arrive on the slave stream: tuser is the mode (insert or lookup),
// tdata holds the key and the value handle. Each request gives exactly one
// result on the master stream, in request order: tuser is the status
// (inserted, found, not found, table full), tdata the stored handle when
// found and zero otherwise.
// The home slot is a djb2 hash of the key bytes; collisions walk a
// triangular probe chain. A full chain of 16384 probes ends in table full.
// After reset the key store is cleared one slot per cycle, all 16384 slots,
// while o_s_tready stays low. Each probe passes through S_READ (registered
// read of the key memory), then S_CHECK (the compare); S_IDLE first takes
// the request from the queue. The engine takes no new request until the
// current result is in the output register. The front part and a
// two-entry queue keep accepting while the engine works. A finished
// result waits in the output register; if the receiver stalls, the engine
// holds the next result and stops, and the queue fills before o_s_tready
// drops.
// ----------------------------------------------------------------------------
module open_address_hash_table
    import oaht_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [IN_DATA_BITS-1:0]  i_s_tdata,   // [31:0] key, [47:32] value
    input  logic                     i_s_tuser,   // [0] mode
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [OUT_DATA_BITS-1:0] o_m_tdata,   // [15:0] found_value
    output logic [1:0]               o_m_tuser    // [1:0] status
);

    logic cleared;
    logic push_valid;
    logic push_ready;
    t_req push_req;
    logic pop_valid;
    logic pop_ready;
    t_req pop_req;

    // Request intake and hashing
    oaht_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_enable   (cleared),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_valid  (push_valid),
        .i_q_ready  (push_ready),
        .o_q_req    (push_req)
    );

    // Request queue
    oaht_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_req   (push_req),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_req    (pop_req)
    );

    // Probe engine and result register
    oaht_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .o_cleared    (cleared),
        .i_q_valid    (pop_valid),
        .o_q_ready    (pop_ready),
        .i_q_req      (pop_req),
        .o_res_valid  (o_m_tvalid),
        .i_res_ready  (i_m_tready),
        .o_res_status (o_m_tuser),
        .o_res_value  (o_m_tdata)
    );

endmodule

// ----- hdl/oaht_checker.sv -----
// ----------------------------------------------------------------------------
// oaht_checker
// Port-level checks for the hash table, bound to the top level.
// ----------------------------------------------------------------------------
module oaht_checker
    import oaht_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_s_tready,
    input logic                     o_m_tvalid,
    input logic                     i_m_tready,
    input logic [OUT_DATA_BITS-1:0] o_m_tdata,
    input logic [1:0]               o_m_tuser
);

    // Reset starts the clear pass: nothing taken, nothing offered
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready && !o_m_tvalid)
        else $error("ready or valid right after reset");

    // Handle is zero unless the key was found
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != ST_FOUND |-> o_m_tdata == '0)
        else $error("nonzero handle on a result that is not found");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

endmodule

bind open_address_hash_table oaht_checker u_oaht_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ----- verif/open_address_hash_table_tb.sv -----
// ----------------------------------------------------------------------------
// open_address_hash_table_tb
// Self-checking bench for the open-addressed hash table. It keeps its own
// copy of the key and handle stores and works out every result.
// ----------------------------------------------------------------------------
// Phases: a short directed run (empty lookups, extreme keys and handles,
// zero keys, duplicate and colliding keys), about 1500 random requests at
// light load with a full drain halfway, and a few closing requests that
// include zero keys.
// Both stream sides idle at random per request; some stretches run with
// no idling at all.
// ----------------------------------------------------------------------------
module open_address_hash_table_tb;
    import oaht_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int SETTLE_CYCLES  = 100;
    localparam int TIMEOUT_CYCLES = 6_000_000;
    localparam int MAX_IDLE       = 19;

    // One predicted result
    typedef struct packed {
        logic [1:0]            status;
        logic [VALUE_BITS-1:0] handle;
    } t_outcome;

    // Shadow of the key/handle stores plus the queue of results still due
    class table_tracker;
        bit [KEY_BITS-1:0]   key_at    [TABLE_SLOTS];
        bit [VALUE_BITS-1:0] handle_at [TABLE_SLOTS];
        t_outcome            due_results [$];
        int unsigned         used_slots;
        int unsigned         errors;
        int unsigned         tally [4];

        // djb2 over the key bytes, low byte first, full 32-bit wrap
        function int unsigned home_of(bit [KEY_BITS-1:0] key);
            bit [31:0] h;
            h = 32'd5381;
            for (int b = 0; b < 4; b++)
                h = (h * 32'd33) ^ {24'd0, key[b*8 +: 8]};
            return h % TABLE_SLOTS;
        endfunction

        // Walk the triangular probe chain and update the shadow stores
        function t_outcome resolve(bit mode, bit [KEY_BITS-1:0] key,
                                   bit [VALUE_BITS-1:0] handle);
            t_outcome    res;
            int unsigned slot;
            res.status = ST_FULL;
            res.handle = '0;
            if (key == '0) begin
                res.status = ST_MISSING;
                return res;
            end
            slot = home_of(key);
            for (int unsigned probe = 1; probe <= TABLE_SLOTS; probe++) begin
                if (mode == MODE_INSERT) begin
                    if (key_at[slot] == '0) begin
                        key_at[slot]    = key;
                        handle_at[slot] = handle;
                        used_slots++;
                        res.status = ST_INSERTED;
                        break;
                    end
                end else begin
                    if (key_at[slot] == '0) begin
                        res.status = ST_MISSING;
                        break;
                    end
                    if (key_at[slot] == key) begin
                        res.status = ST_FOUND;
                        res.handle = handle_at[slot];
                        break;
                    end
                end
                slot = (slot + probe) % TABLE_SLOTS;
            end
            return res;
        endfunction

        function void note_request(bit mode, bit [KEY_BITS-1:0] key,
                                   bit [VALUE_BITS-1:0] handle);
            t_outcome res;
            res = resolve(mode, key, handle);
            tally[res.status]++;
            due_results.push_back(res);
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        task flag(string what);
            errors++;
            $display("MISMATCH @%0t: %s", $time, what);
        endtask

        task check_result(logic [1:0] status, logic [VALUE_BITS-1:0] handle);
            t_outcome want;
            if (due_results.size() == 0) begin
                flag($sformatf("result with none due: status %0d handle %h",
                               status, handle));
                return;
            end
            want = due_results.pop_front();
            if (status !== want.status)
                flag($sformatf("status %0d, predicted %0d", status, want.status));
            if (handle !== want.handle)
                flag($sformatf("found_value %h, predicted %h", handle, want.handle));
        endtask
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_s_tvalid;
    logic                     o_s_tready;
    logic [IN_DATA_BITS-1:0]  i_s_tdata;   // [31:0] key, [47:32] value
    logic                     i_s_tuser;   // [0] mode
    logic                     o_m_tvalid;
    logic                     i_m_tready;
    logic [OUT_DATA_BITS-1:0] o_m_tdata;   // [15:0] found_value
    logic [1:0]               o_m_tuser;   // [1:0] status

    table_tracker        tracker = new;
    bit [KEY_BITS-1:0]   stored_keys [$];
    bit                  quiet;

    open_address_hash_table i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Random nonzero key
    function automatic bit [KEY_BITS-1:0] any_key();
        bit [KEY_BITS-1:0] k;
        k = $urandom;
        if (k == '0)
            k = 32'd1;
        return k;
    endfunction

    // Random value handle
    function automatic bit [VALUE_BITS-1:0] any_handle();
        return VALUE_BITS'($urandom);
    endfunction

    // Search for another key with the same home slot as anchor
    function automatic bit [KEY_BITS-1:0] collider(bit [KEY_BITS-1:0] anchor);
        int unsigned       target;
        bit [KEY_BITS-1:0] k;
        target = tracker.home_of(anchor);
        for (int n = 0; n < (1 << 20); n++) begin
            k = $urandom;
            if (k != '0 && k != anchor && tracker.home_of(k) == target)
                return k;
        end
        return any_key();
    endfunction

    function automatic bit [KEY_BITS-1:0] known_key();
        return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    endfunction

    // Send one request; returns at the edge where it was taken
    task automatic issue(bit mode, bit [KEY_BITS-1:0] key, bit [VALUE_BITS-1:0] handle);
        int unsigned gap;
        gap = $urandom_range(0, MAX_IDLE);
        if (quiet)
            gap = 0;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {handle, key};
        i_s_tuser  <= mode;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        tracker.note_request(mode, key, handle);
        if (mode == MODE_INSERT && key != '0)
            stored_keys.push_back(key);
    endtask

    // Hold off the sender until every due result has come back
    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    // Receiver: random stall before each result
    initial begin
        int unsigned stall;
        forever begin
            stall = $urandom_range(0, MAX_IDLE);
            if (quiet)
                stall = 0;
            if (stall != 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_tvalid !== 1'b1);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_m_tvalid === 1'b1 && i_m_tready === 1'b1)
            tracker.check_result(o_m_tuser, o_m_tdata);
    end

    // Watchdog
    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("Timeout with %0d results outstanding", tracker.pending());
        $display("open_address_hash_table verification failed");
        $finish;
    end

    // Stimulus
    initial begin
        bit [KEY_BITS-1:0] k;
        bit [KEY_BITS-1:0] side;
        int unsigned       pick;
        int unsigned       n;

        quiet = 1'b0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= MODE_INSERT;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, extreme keys and handles, zero keys
        issue(MODE_LOOKUP, 32'd1, 16'hFFFF);
        issue(MODE_INSERT, 32'd1, 16'h0000);
        issue(MODE_LOOKUP, 32'd1, 16'h0000);
        issue(MODE_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        issue(MODE_LOOKUP, 32'hFFFF_FFFF, 16'h0000);
        issue(MODE_INSERT, 32'd0, 16'h1234);
        issue(MODE_LOOKUP, 32'd0, 16'hFFFF);
        // duplicate insert: lookup still returns the earlier slot
        issue(MODE_INSERT, 32'hFFFF_FFFF, 16'h5A5A);
        issue(MODE_LOOKUP, 32'hFFFF_FFFF, 16'hA5A5);
        // keys sharing a home slot walk the probe chain
        issue(MODE_INSERT, 32'h8000_0000, 16'h8000);
        k = collider(32'h8000_0000);
        issue(MODE_INSERT, k, 16'h0001);
        side = collider(32'h8000_0000);
        issue(MODE_INSERT, side, 16'h7FFF);
        issue(MODE_LOOKUP, side, 16'h0000);
        issue(MODE_LOOKUP, k, 16'hFFFF);
        issue(MODE_LOOKUP, collider(32'h8000_0000), 16'h0000);
        issue(MODE_LOOKUP, 32'h8000_0000, 16'h0000);
        issue(MODE_INSERT, 32'h0000_0100, 16'hAAAA);
        issue(MODE_LOOKUP, 32'h0000_0100, 16'h5555);
        issue(MODE_LOOKUP, 32'h1234_5678, 16'h0000);
        drain();

        // Random mix at light load
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_ITEMS / 2)
                drain();
            pick = $urandom_range(0, 99);
            if (pick < 40)
                issue(MODE_INSERT, any_key(), any_handle());
            else if (pick < 44)
                issue(MODE_INSERT, collider(known_key()), any_handle());
            else if (pick < 50)
                issue(MODE_INSERT, known_key(), any_handle());
            else if (pick < 85)
                issue(MODE_LOOKUP, known_key(), any_handle());
            else if (pick < 97)
                issue(MODE_LOOKUP, any_key(), any_handle());
            else
                issue(1'($urandom_range(0, 1)), 32'd0, any_handle());
        end

        // Closing requests, zero keys included
        quiet = 1'b0;
        issue(MODE_INSERT, any_key(), any_handle());
        issue(MODE_INSERT, known_key(), any_handle());
        issue(MODE_LOOKUP, any_key(), any_handle());
        issue(MODE_LOOKUP, known_key(), any_handle());
        issue(MODE_LOOKUP, known_key(), any_handle());
        issue(MODE_INSERT, 32'd0, any_handle());
        issue(MODE_LOOKUP, 32'd0, any_handle());
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (tracker.pending() != 0)
            tracker.flag($sformatf("%0d results never arrived", tracker.pending()));
        $display("Requests: %0d inserted, %0d found, %0d not found, %0d table full",
                 tracker.tally[ST_INSERTED], tracker.tally[ST_FOUND],
                 tracker.tally[ST_MISSING], tracker.tally[ST_FULL]);
        $display("Key store filled to %0d of %0d slots; %0d mismatches",
                 tracker.used_slots, TABLE_SLOTS, tracker.errors);
        if (tracker.errors == 0)
            $display("open_address_hash_table verification clean");
        else
            $display("open_address_hash_table verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/oaht_pkg.sv
hdl/oaht_front.sv
hdl/oaht_queue.sv
hdl/oaht_back.sv
hdl/open_address_hash_table.sv
hdl/oaht_checker.sv
verif/open_address_hash_table_tb.sv
